// ===== rtl/esr_pkg.sv =====
// Shared constants for the ellipse span rasteriser.
`timescale 1ns / 1ps

package esr_pkg;

    // Default radius width
    localparam int RADIUS_BITS_DEF = 10;

    // Field widths of the streaming words
    localparam int COORD_W   = 16;
    localparam int RAD_IN_W  = 10;
    localparam int SIZE_W    = 8;
    localparam int RGB24_W   = 24;
    localparam int RGB565_W  = 16;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USER_W = 2;

    // Walk phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_R1   = 2'd1;
    localparam logic [1:0] PH_R2   = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    // Input kinds
    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    // Index of the last result per iteration
    localparam logic [1:0] LAST_IDX_SPAN   = 2'd1;
    localparam logic [1:0] LAST_IDX_SQUARE = 2'd3;

    // Decision update offsets
    localparam int STEP_FOUR = 4;
    localparam int STEP_SIX  = 6;

    // Colour packing to red5 green6 blue5
    function automatic logic [RGB565_W-1:0] to_rgb565(input logic [RGB24_W-1:0] c);
        to_rgb565 = {c[7:3], c[15:10], c[23:19]};
    endfunction

endpackage

// ===== rtl/ellipse_span_rasterizer_core.sv =====
// Midpoint ellipse walker: one iteration per step word, squares or spans out.
`timescale 1ns / 1ps

// A start word (tuser 0) latches centre, radii, fill flag, dot size and colour,
// then squares the radii and seeds the region 1 decision in set-up states ST1
// to ST4; input is held off meanwhile. Each step word (tuser 1) runs one
// iteration of the midpoint ellipse walk: the region test products (T1, T2),
// the compare, the results one per cycle unless the output stalls (two spans
// in fill mode, four squares in outline mode) and the decision update (U1 to
// U3), after which input is taken again. A step that crosses from region 1 to
// region 2 adds set-up (SW, SW2) and a second region test. Once the ellipse is
// finished every step returns one result with shape_done set and is then ready
// again; the step whose region 2 test fails returns it after its test. All
// products go through a single registered signed multiplier.
module ellipse_span_rasterizer_core #(
    parameter int RADIUS_BITS = esr_pkg::RADIUS_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input words
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata, low bit up: center_x[15:0], center_y[31:16], radius_x[41:32],
    // radius_y[51:42], fill_enable[52], dot_size[60:53], color_rgb24[84:61], zero pad
    input  logic [esr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // tuser: mode
    input  logic                            s_axis_tuser,
    // Result words
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata, low bit up: x_first[15:0], x_final[31:16], y_row[47:32],
    // thickness[55:48], color_rgb565[71:56]
    output logic [esr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // tuser, low bit up: is_span[0], shape_done[1]
    output logic [esr_pkg::OUT_USER_W-1:0]  m_axis_tuser,
    output logic                            m_axis_tlast
);

    localparam int WALK_W = RADIUS_BITS + 2;
    localparam int SQ_W   = 2 * RADIUS_BITS;
    localparam int MA_W   = SQ_W + 1;
    localparam int MB_W   = RADIUS_BITS + 5;
    localparam int PROD_W = MA_W + MB_W;
    localparam int DEC_W  = PROD_W + 2;
    localparam int CW     = esr_pkg::COORD_W;

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ST1  = 4'd1;
    localparam logic [3:0] S_ST2  = 4'd2;
    localparam logic [3:0] S_ST3  = 4'd3;
    localparam logic [3:0] S_ST4  = 4'd4;
    localparam logic [3:0] S_T1   = 4'd5;
    localparam logic [3:0] S_T2   = 4'd6;
    localparam logic [3:0] S_CMP  = 4'd7;
    localparam logic [3:0] S_EMIT = 4'd8;
    localparam logic [3:0] S_U1   = 4'd9;
    localparam logic [3:0] S_U2   = 4'd10;
    localparam logic [3:0] S_U3   = 4'd11;
    localparam logic [3:0] S_SW   = 4'd12;
    localparam logic [3:0] S_SW2  = 4'd13;
    localparam logic [3:0] S_FIN  = 4'd14;

    // Input fields
    logic [CW-1:0]                     in_center_x;
    logic [CW-1:0]                     in_center_y;
    logic [esr_pkg::RAD_IN_W-1:0]      in_radius_x;
    logic [esr_pkg::RAD_IN_W-1:0]      in_radius_y;
    logic                              in_fill;
    logic [esr_pkg::SIZE_W-1:0]        in_size;
    logic [esr_pkg::RGB24_W-1:0]       in_color;
    logic [RADIUS_BITS-1:0]            rx_in;
    logic [RADIUS_BITS-1:0]            ry_in;

    assign in_center_x = s_axis_tdata[15:0];
    assign in_center_y = s_axis_tdata[31:16];
    assign in_radius_x = s_axis_tdata[41:32];
    assign in_radius_y = s_axis_tdata[51:42];
    assign in_fill     = s_axis_tdata[52];
    assign in_size     = s_axis_tdata[60:53];
    assign in_color    = s_axis_tdata[84:61];
    assign rx_in       = RADIUS_BITS'(in_radius_x);
    assign ry_in       = RADIUS_BITS'(in_radius_y);

    // State
    logic [3:0]                   state_reg, state_next;
    logic [1:0]                   phase_reg, phase_next;
    logic signed [WALK_W-1:0]     walk_x_reg, walk_x_next;
    logic signed [WALK_W-1:0]     walk_y_reg, walk_y_next;
    logic signed [DEC_W-1:0]      dec_reg, dec_next;
    logic [SQ_W-1:0]              rx_sq_reg, rx_sq_next;
    logic [SQ_W-1:0]              ry_sq_reg, ry_sq_next;
    logic [RADIUS_BITS-1:0]       srx_reg, srx_next;
    logic [CW-1:0]                scx_reg, scx_next;
    logic [CW-1:0]                scy_reg, scy_next;
    logic                         sfill_reg, sfill_next;
    logic [esr_pkg::SIZE_W-1:0]   ssize_reg, ssize_next;
    logic [esr_pkg::RGB565_W-1:0] scolor_reg, scolor_next;
    logic [1:0]                   idx_reg, idx_next;
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [PROD_W-1:0]     hold_reg, hold_next;

    // Output register
    logic                             ovalid_reg, ovalid_next;
    logic [esr_pkg::OUT_DATA_W-1:0]   odata_reg, odata_next;
    logic [esr_pkg::OUT_USER_W-1:0]   ouser_reg, ouser_next;
    logic                             olast_reg, olast_next;

    logic in_acc;
    logic out_free;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !ovalid_reg || m_axis_tready;

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = ouser_reg;
    assign m_axis_tlast  = olast_reg;

    // Region roles: u walks up, v walks down
    logic signed [WALK_W-1:0] u_w, v_w;
    logic [SQ_W-1:0]          su, sv;
    logic in_r1;

    assign in_r1 = (phase_reg == esr_pkg::PH_R1);
    assign u_w   = in_r1 ? walk_x_reg : walk_y_reg;
    assign v_w   = in_r1 ? walk_y_reg : walk_x_reg;
    assign su    = in_r1 ? ry_sq_reg : rx_sq_reg;
    assign sv    = in_r1 ? rx_sq_reg : ry_sq_reg;

    // Shared multiplier operands
    logic signed [MB_W-1:0] u_b, v_b, wy_b, srx_b;
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;

    assign u_b   = MB_W'(u_w);
    assign v_b   = MB_W'(v_w);
    assign wy_b  = MB_W'(walk_y_reg);
    assign srx_b = signed'(MB_W'(srx_reg));

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_ST1:
            begin
                mul_a = signed'(MA_W'(srx_reg));
                mul_b = srx_b;
            end
            S_ST2:
            begin
                mul_a = MA_W'(walk_y_reg);
                mul_b = wy_b;
            end
            S_ST3:
            begin
                mul_a = signed'(MA_W'(rx_sq_reg));
                mul_b = MB_W'(1) - (wy_b <<< 1);
            end
            S_T1:
            begin
                mul_a = signed'(MA_W'(su));
                mul_b = u_b;
            end
            S_T2:
            begin
                mul_a = signed'(MA_W'(sv));
                mul_b = v_b;
            end
            S_U1:
            begin
                mul_a = signed'(MA_W'(sv));
                mul_b = MB_W'(esr_pkg::STEP_FOUR) - (v_b <<< 2);
            end
            S_U2:
            begin
                mul_a = signed'(MA_W'(su));
                mul_b = (u_b <<< 2) + MB_W'(esr_pkg::STEP_SIX);
            end
            S_SW:
            begin
                mul_a = signed'(MA_W'(ry_sq_reg));
                mul_b = MB_W'(1) - (srx_b <<< 1);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Product register
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a * mul_b);
        hold_reg <= hold_next;
    end

    // Region test and decision helpers
    logic test_pass;
    logic signed [DEC_W-1:0] prod_ext;

    assign test_pass = !v_w[WALK_W-1] && (hold_reg <= prod_reg);
    assign prod_ext  = DEC_W'(prod_reg);

    // Result fields for the current index
    logic [CW-1:0] wx16, wy16;
    logic [CW-1:0] xa, xb, yr;
    logic [1:0]    last_idx;

    assign wx16     = CW'(walk_x_reg);
    assign wy16     = CW'(walk_y_reg);
    assign last_idx = sfill_reg ? esr_pkg::LAST_IDX_SPAN : esr_pkg::LAST_IDX_SQUARE;

    always_comb
    begin
        if (sfill_reg)
        begin
            xa = scx_reg - wx16;
            xb = scx_reg + wx16 + CW'(1) - CW'(ssize_reg);
            yr = idx_reg[0] ? (scy_reg + wy16) : (scy_reg - wy16);
        end
        else
        begin
            xa = idx_reg[0] ? (scx_reg - wx16) : (scx_reg + wx16);
            xb = xa;
            yr = idx_reg[1] ? (scy_reg - wy16) : (scy_reg + wy16);
        end
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        walk_x_next = walk_x_reg;
        walk_y_next = walk_y_reg;
        dec_next    = dec_reg;
        rx_sq_next  = rx_sq_reg;
        ry_sq_next  = ry_sq_reg;
        srx_next    = srx_reg;
        scx_next    = scx_reg;
        scy_next    = scy_reg;
        sfill_next  = sfill_reg;
        ssize_next  = ssize_reg;
        scolor_next = scolor_reg;
        idx_next    = idx_reg;
        hold_next   = hold_reg;
        ovalid_next = ovalid_reg && !m_axis_tready;
        odata_next  = odata_reg;
        ouser_next  = ouser_reg;
        olast_next  = olast_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_axis_tuser == esr_pkg::MODE_START)
                    begin
                        scx_next    = in_center_x;
                        scy_next    = in_center_y;
                        sfill_next  = in_fill;
                        ssize_next  = in_size;
                        scolor_next = esr_pkg::to_rgb565(in_color);
                        srx_next    = rx_in;
                        walk_x_next = '0;
                        walk_y_next = signed'(WALK_W'(ry_in));
                        state_next  = S_ST1;
                    end
                    else if (phase_reg == esr_pkg::PH_R1 || phase_reg == esr_pkg::PH_R2)
                    begin
                        state_next = S_T1;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            // Set-up: squares and region 1 seed
            S_ST1: state_next = S_ST2;
            S_ST2:
            begin
                rx_sq_next = SQ_W'(prod_reg);
                state_next = S_ST3;
            end
            S_ST3:
            begin
                ry_sq_next = SQ_W'(prod_reg);
                state_next = S_ST4;
            end
            S_ST4:
            begin
                dec_next   = (DEC_W'(ry_sq_reg) <<< 1) + prod_ext;
                phase_next = esr_pkg::PH_R1;
                state_next = S_IDLE;
            end
            // Region test
            S_T1: state_next = S_T2;
            S_T2:
            begin
                hold_next  = prod_reg;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                idx_next = '0;
                if (test_pass)
                begin
                    state_next = S_EMIT;
                end
                else if (in_r1)
                begin
                    state_next = S_SW;
                end
                else
                begin
                    phase_next = esr_pkg::PH_DONE;
                    state_next = S_FIN;
                end
            end
            // Results of this iteration
            S_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = {scolor_reg, ssize_reg, yr, xb, xa};
                    ouser_next  = {1'b0, sfill_reg};
                    olast_next  = (idx_reg == last_idx);
                    if (idx_reg == last_idx)
                    begin
                        state_next = S_U1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end
            // Decision update
            S_U1: state_next = S_U2;
            S_U2:
            begin
                if (!dec_reg[DEC_W-1])
                begin
                    dec_next = dec_reg + prod_ext;
                    if (in_r1)
                    begin
                        walk_y_next = walk_y_reg - WALK_W'(1);
                    end
                    else
                    begin
                        walk_x_next = walk_x_reg - WALK_W'(1);
                    end
                end
                state_next = S_U3;
            end
            S_U3:
            begin
                dec_next = dec_reg + prod_ext;
                if (in_r1)
                begin
                    walk_x_next = walk_x_reg + WALK_W'(1);
                end
                else
                begin
                    walk_y_next = walk_y_reg + WALK_W'(1);
                end
                state_next = S_IDLE;
            end
            // Switch to region 2
            S_SW:
            begin
                walk_x_next = signed'(WALK_W'(srx_reg));
                walk_y_next = '0;
                state_next  = S_SW2;
            end
            S_SW2:
            begin
                dec_next   = (DEC_W'(rx_sq_reg) <<< 1) + prod_ext;
                phase_next = esr_pkg::PH_R2;
                state_next = S_T1;
            end
            // Completion word
            S_FIN:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = {scolor_reg, ssize_reg, {(3 * CW){1'b0}}};
                    ouser_next  = 2'b10;
                    olast_next  = 1'b1;
                    phase_next  = esr_pkg::PH_DONE;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= esr_pkg::PH_IDLE;
            walk_x_reg <= '0;
            walk_y_reg <= '0;
            dec_reg    <= '0;
            rx_sq_reg  <= '0;
            ry_sq_reg  <= '0;
            srx_reg    <= '0;
            scx_reg    <= '0;
            scy_reg    <= '0;
            sfill_reg  <= 1'b0;
            ssize_reg  <= esr_pkg::SIZE_W'(1);
            scolor_reg <= '0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            walk_x_reg <= walk_x_next;
            walk_y_reg <= walk_y_next;
            dec_reg    <= dec_next;
            rx_sq_reg  <= rx_sq_next;
            ry_sq_reg  <= ry_sq_next;
            srx_reg    <= srx_next;
            scx_reg    <= scx_next;
            scy_reg    <= scy_next;
            sfill_reg  <= sfill_next;
            ssize_reg  <= ssize_next;
            scolor_reg <= scolor_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        odata_reg <= odata_next;
        ouser_reg <= ouser_next;
        olast_reg <= olast_next;
    end

    // Checks
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tlast && !m_axis_tuser[0]))
        else $error("completion word without tlast or with span flag");

    a_start_setup: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_axis_tuser == esr_pkg::MODE_START) |=> (state_reg == S_ST1))
        else $error("start word did not enter set-up");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (idx_reg <= last_idx))
        else $error("result index beyond run length");

    a_r2_fail_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP && !test_pass && phase_reg == esr_pkg::PH_R2)
        |=> (phase_reg == esr_pkg::PH_DONE && state_reg == S_FIN))
        else $error("region 2 exit did not finish the ellipse");

endmodule

// ===== tb/ellipse_span_rasterizer_core_tb.sv =====
// Self-checking stream testbench for the midpoint ellipse span rasteriser core.
`timescale 1ns / 1ps

module ellipse_span_rasterizer_core_tb;

    localparam int RADIUS_BITS  = esr_pkg::RADIUS_BITS_DEF;
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = 40;

    // One input word, fields as the block sees them
    typedef struct {
        logic               mode;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [9:0]         rx;
        logic [9:0]         ry;
        logic               fill;
        logic [7:0]         size;
        logic [23:0]        colour;
    } in_word_t;

    // One result word
    typedef struct {
        logic [15:0] x_first;
        logic [15:0] x_final;
        logic [15:0] y_row;
        logic [7:0]  thickness;
        logic [15:0] colour;
        logic        is_span;
        logic        last;
        logic        done;
    } plot_word_t;

    // Ellipse walker model plus the queue of plot words it predicts
    class ellipse_scoreboard_t;
        plot_word_t  plot_queue[$];
        int          errors;
        int          n_squares;
        int          n_spans;
        int          n_done;
        int unsigned rmask;

        logic [1:0]  phase;
        int          walk_x;
        int          walk_y;
        longint      decision;
        longint      rx_sq;
        longint      ry_sq;
        int          keep_rx;
        logic [15:0] keep_cx;
        logic [15:0] keep_cy;
        logic        keep_fill;
        logic [7:0]  keep_size;
        logic [15:0] keep_colour;

        function new(int radius_bits);
            rmask       = (1 << radius_bits) - 1;
            errors      = 0;
            n_squares   = 0;
            n_spans     = 0;
            n_done      = 0;
            phase       = esr_pkg::PH_IDLE;
            walk_x      = 0;
            walk_y      = 0;
            decision    = 0;
            rx_sq       = 0;
            ry_sq       = 0;
            keep_rx     = 0;
            keep_cx     = '0;
            keep_cy     = '0;
            keep_fill   = 1'b0;
            keep_size   = 8'd1;
            keep_colour = '0;
        endfunction

        function int pending();
            return plot_queue.size();
        endfunction

        function void queue_plot(logic [15:0] xa, logic [15:0] xb, logic [15:0] y,
                                 logic span, logic done, logic last);
            plot_word_t p;
            p.x_first   = xa;
            p.x_final   = xb;
            p.y_row     = y;
            p.thickness = keep_size;
            p.colour    = keep_colour;
            p.is_span   = span;
            p.last      = last;
            p.done      = done;
            plot_queue.push_back(p);
        endfunction

        // Four squares or two spans for the current walk point
        function void plot_point();
            logic [15:0] ux;
            logic [15:0] uy;
            logic [15:0] xa;
            logic [15:0] xb;
            ux = walk_x[15:0];
            uy = walk_y[15:0];
            if (keep_fill)
            begin
                xa = keep_cx - ux;
                xb = keep_cx + ux + 16'd1 - {8'd0, keep_size};
                queue_plot(xa, xb, keep_cy - uy, 1'b1, 1'b0, 1'b0);
                queue_plot(xa, xb, keep_cy + uy, 1'b1, 1'b0, 1'b1);
            end
            else
            begin
                queue_plot(keep_cx + ux, keep_cx + ux, keep_cy + uy, 1'b0, 1'b0, 1'b0);
                queue_plot(keep_cx - ux, keep_cx - ux, keep_cy + uy, 1'b0, 1'b0, 1'b0);
                queue_plot(keep_cx + ux, keep_cx + ux, keep_cy - uy, 1'b0, 1'b0, 1'b0);
                queue_plot(keep_cx - ux, keep_cx - ux, keep_cy - uy, 1'b0, 1'b0, 1'b1);
            end
        endfunction

        // Advance the model by one accepted input word
        function void note_input(in_word_t w);
            int rx;
            int ry;
            if (w.mode == esr_pkg::MODE_START)
            begin
                rx          = int'(w.rx) & rmask;
                ry          = int'(w.ry) & rmask;
                keep_cx     = w.cx;
                keep_cy     = w.cy;
                keep_fill   = w.fill;
                keep_size   = w.size;
                keep_colour = {w.colour[7:3], w.colour[15:10], w.colour[23:19]};
                keep_rx     = rx;
                rx_sq       = longint'(rx) * rx;
                ry_sq       = longint'(ry) * ry;
                walk_x      = 0;
                walk_y      = ry;
                decision    = 2 * ry_sq + rx_sq * (1 - 2 * longint'(ry));
                phase       = esr_pkg::PH_R1;
                return;
            end

            // Region 1: x steps, y steps when the decision says so
            if (phase == esr_pkg::PH_R1)
            begin
                if (walk_y >= 0 && ry_sq * walk_x <= rx_sq * walk_y)
                begin
                    plot_point();
                    if (decision >= 0)
                    begin
                        decision += esr_pkg::STEP_FOUR * rx_sq * (1 - longint'(walk_y));
                        walk_y--;
                    end
                    decision += ry_sq * (esr_pkg::STEP_FOUR * longint'(walk_x)
                                         + esr_pkg::STEP_SIX);
                    walk_x++;
                    return;
                end
                walk_x   = keep_rx;
                walk_y   = 0;
                decision = 2 * rx_sq + ry_sq * (1 - 2 * longint'(keep_rx));
                phase    = esr_pkg::PH_R2;
            end

            // Region 2: y steps, x steps back when the decision says so
            if (phase == esr_pkg::PH_R2)
            begin
                if (walk_x >= 0 && rx_sq * walk_y <= ry_sq * walk_x)
                begin
                    plot_point();
                    if (decision >= 0)
                    begin
                        decision += esr_pkg::STEP_FOUR * ry_sq * (1 - longint'(walk_x));
                        walk_x--;
                    end
                    decision += rx_sq * (esr_pkg::STEP_FOUR * longint'(walk_y)
                                         + esr_pkg::STEP_SIX);
                    walk_y++;
                    return;
                end
            end

            // Finished, or stepped while idle
            phase = esr_pkg::PH_DONE;
            queue_plot(16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 1'b1);
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        // Compare one accepted result word with the oldest prediction
        task check_result(plot_word_t got);
            plot_word_t want;
            if (got.done)
                n_done++;
            else if (got.is_span)
                n_spans++;
            else
                n_squares++;
            if (plot_queue.size() == 0)
            begin
                report("result word with nothing predicted");
                return;
            end
            want = plot_queue.pop_front();
            if (got.x_first !== want.x_first)
                report($sformatf("x_first %h, want %h", got.x_first, want.x_first));
            if (got.x_final !== want.x_final)
                report($sformatf("x_final %h, want %h", got.x_final, want.x_final));
            if (got.y_row !== want.y_row)
                report($sformatf("y_row %h, want %h", got.y_row, want.y_row));
            if (got.thickness !== want.thickness)
                report($sformatf("thickness %h, want %h", got.thickness, want.thickness));
            if (got.colour !== want.colour)
                report($sformatf("colour %h, want %h", got.colour, want.colour));
            if (got.is_span !== want.is_span)
                report($sformatf("is_span %b, want %b", got.is_span, want.is_span));
            if (got.last !== want.last)
                report($sformatf("last %b, want %b", got.last, want.last));
            if (got.done !== want.done)
                report($sformatf("shape_done %b, want %b", got.done, want.done));
        endtask
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [esr_pkg::IN_DATA_W-1:0]   s_axis_tdata;
    logic                            s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [esr_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
    logic [esr_pkg::OUT_USER_W-1:0]  m_axis_tuser;
    logic                            m_axis_tlast;

    ellipse_scoreboard_t sb;
    int  src_idle_pct;
    int  snk_stall_pct;
    bit  hold_req;
    bit  hold_used;
    int  hold_left;
    int  cycle_count;
    int  words_sent;

    ellipse_span_rasterizer_core #(
        .RADIUS_BITS(RADIUS_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    // Clock, 4 ns period
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run-away guard
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Output back-pressure, with one long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        hold_left     = 0;
        hold_used     = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_used)
            begin
                hold_left = HOLD_CYCLES;
                hold_used = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        plot_word_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.x_first   = m_axis_tdata[15:0];
            got.x_final   = m_axis_tdata[31:16];
            got.y_row     = m_axis_tdata[47:32];
            got.thickness = m_axis_tdata[55:48];
            got.colour    = m_axis_tdata[71:56];
            got.is_span   = m_axis_tuser[0];
            got.done      = m_axis_tuser[1];
            got.last      = m_axis_tlast;
            sb.check_result(got);
        end
    end

    function automatic in_word_t rand_word(logic mode);
        in_word_t w;
        w.mode   = mode;
        w.cx     = 16'($urandom);
        w.cy     = 16'($urandom);
        w.rx     = 10'($urandom);
        w.ry     = 10'($urandom);
        w.fill   = 1'($urandom);
        w.size   = 8'($urandom);
        w.colour = 24'($urandom);
        return w;
    endfunction

    function automatic in_word_t start_word(logic signed [15:0] cx, logic signed [15:0] cy,
                                            logic [9:0] rx, logic [9:0] ry, logic fill,
                                            logic [7:0] size, logic [23:0] colour);
        in_word_t w;
        w.mode   = esr_pkg::MODE_START;
        w.cx     = cx;
        w.cy     = cy;
        w.rx     = rx;
        w.ry     = ry;
        w.fill   = fill;
        w.size   = size;
        w.colour = colour;
        return w;
    endfunction

    // Offer one word, called and returning at a falling edge
    task automatic send_word(in_word_t w);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= w.mode;
        s_axis_tdata  <= {3'b000, w.colour, w.size, w.fill, w.ry, w.rx, w.cy, w.cx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_input(w);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_steps(int n);
        repeat (n) send_word(rand_word(esr_pkg::MODE_ADVANCE));
    endtask

    // Random shapes: mostly small complete walks, some cut short, some stray steps
    task automatic run_random_shapes(int n_words);
        int       sent;
        int       kind;
        int       steps;
        in_word_t w;
        sent = 0;
        while (sent < n_words)
        begin
            kind = $urandom_range(99);
            if (kind < 10)
            begin
                steps = $urandom_range(1, 4);
                send_steps(steps);
                sent += steps;
            end
            else
            begin
                w = rand_word(esr_pkg::MODE_START);
                if (kind < 16)
                    steps = $urandom_range(1, 8);
                else
                begin
                    w.rx = 10'($urandom_range(0, 12));
                    w.ry = 10'($urandom_range(0, 12));
                    if (kind < 85)
                        steps = w.rx + w.ry + 4 + $urandom_range(0, 2);
                    else
                        steps = $urandom_range(0, w.rx + w.ry + 2);
                end
                send_word(w);
                send_steps(steps);
                sent += steps + 1;
            end
        end
    endtask

    // Main sequence
    initial
    begin
        sb            = new(RADIUS_BITS);
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = esr_pkg::MODE_START;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_req      = 1'b0;
        words_sent    = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Step while idle: completion word with reset size and colour
        send_steps(1);
        // Both radii zero, corner centre, zero dot size: one point per region
        send_word(start_word(16'sh8000, 16'sh7FFF, 10'd0, 10'd0, 1'b0, 8'd0, 24'hFFFFFF));
        send_steps(3);
        // Small filled walk that wraps, span end left of start
        send_word(start_word(16'sh7FFF, 16'sh8000, 10'd2, 10'd1, 1'b1, 8'd255, 24'h000000));
        send_steps(6);
        // Largest radii, a few steps only
        send_word(start_word(16'sh0000, 16'sh0000, 10'h3FF, 10'h3FF, 1'b0, 8'd1, 24'hA55AC3));
        send_steps(3);
        // Filled, both radii zero, zero thickness
        send_word(start_word(16'sh0010, 16'shFFF0, 10'd0, 10'd0, 1'b1, 8'd0, 24'h3C7E18));
        send_steps(3);

        // Long output hold while input keeps coming
        hold_req = 1'b1;
        run_random_shapes(65);

        src_idle_pct  = 60;
        snk_stall_pct = 0;
        run_random_shapes(65);

        src_idle_pct  = 0;
        snk_stall_pct = 60;
        run_random_shapes(65);

        src_idle_pct  = 11;
        snk_stall_pct = 11;
        run_random_shapes(65);

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report("predicted words never arrived");

        $display("Sent %0d input words; checked %0d squares, %0d spans, %0d completion words",
                 words_sent, sb.n_squares, sb.n_spans, sb.n_done);
        $display("under free flow, input gaps, output stalls, both, and one long output hold");
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
